>>> rtl/jet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_pkg
// Types, constants and tables shared by the effort transform pipeline.
// ----------------------------------------------------------------------------
package jet_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_ENTRIES      = 24;

	localparam int ANG_W = 18;
	localparam int Z_W   = 35;
	localparam int XY_W  = 34;
	localparam int NUM_W = 64;
	localparam int QUO_W = 32;

	localparam logic signed [Z_W-1:0]  ANG_TWO_PI      = 35'sd3373259426;
	localparam logic signed [Z_W-1:0]  ANG_PI          = 35'sd1686629713;
	localparam logic signed [Z_W-1:0]  ANG_HALF_PI     = 35'sd843314857;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

	localparam logic [1:0] CFG_LINK_UPPER = 2'd0;
	localparam logic [1:0] CFG_LINK_FORE  = 2'd1;
	localparam logic [1:0] CFG_LINK_TOOL  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] angle_shoulder;
		logic signed [15:0] angle_elbow;
		logic signed [15:0] angle_wrist;
		logic signed [31:0] effort_in_0;
		logic signed [31:0] effort_in_1;
		logic signed [31:0] effort_in_2;
		logic signed [31:0] effort_in_3;
		logic signed [31:0] effort_in_4;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] effort_out_0;
		logic signed [31:0] effort_out_1;
		logic signed [31:0] effort_out_2;
		logic signed [31:0] effort_out_3;
		logic signed [31:0] effort_out_4;
		logic               singular;
	} out_item_t;

	function automatic logic signed [Z_W-1:0] atan_q(input int idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0: v = 35'sd421657428;
			1: v = 35'sd248918915;
			2: v = 35'sd131521918;
			3: v = 35'sd66762579;
			4: v = 35'sd33510843;
			5: v = 35'sd16771758;
			6: v = 35'sd8387925;
			7: v = 35'sd4194219;
			8: v = 35'sd2097141;
			9: v = 35'sd1048575;
			10: v = 35'sd524288;
			11: v = 35'sd262144;
			12: v = 35'sd131072;
			13: v = 35'sd65536;
			14: v = 35'sd32768;
			15: v = 35'sd16384;
			16: v = 35'sd8192;
			17: v = 35'sd4096;
			18: v = 35'sd2048;
			19: v = 35'sd1024;
			20: v = 35'sd512;
			21: v = 35'sd256;
			22: v = 35'sd128;
			23: v = 35'sd64;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/jet_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_cordic
// Pipelined sine and cosine of a Q.13 angle, one rotation per stage.
// ----------------------------------------------------------------------------
module jet_cordic
	import jet_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [ANG_W-1:0] ang,
	output logic signed [XY_W-1:0]      cos_val,
	output logic signed [XY_W-1:0]      sin_val
);

	localparam int NSTG = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

	logic signed [Z_W-1:0]  a;
	logic                   fold;
	logic signed [Z_W-1:0]  z_s [NSTG+1];
	logic signed [XY_W-1:0] x_s [NSTG+1];
	logic signed [XY_W-1:0] y_s [NSTG+1];
	logic                   neg_s [NSTG+1];

	always_comb begin
		a = Z_W'(ang) <<< 16;
		if (a > ANG_PI) a = a - ANG_TWO_PI;
		if (a > ANG_PI) a = a - ANG_TWO_PI;
		if (a <= -ANG_PI) a = a + ANG_TWO_PI;
		if (a <= -ANG_PI) a = a + ANG_TWO_PI;
		fold = 1'b0;
		if (a > ANG_HALF_PI) begin
			a = a - ANG_PI;
			fold = 1'b1;
		end else if (a < -ANG_HALF_PI) begin
			a = a + ANG_PI;
			fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]   <= a;
			neg_s[0] <= fold;
			x_s[0]   <= CORDIC_GAIN_INV;
			y_s[0]   <= '0;
		end
	end

	for (genvar g = 0; g < NSTG; g++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[g+1] <= neg_s[g];
				if (z_s[g] >= 0) begin
					x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] - atan_q(g);
				end else begin
					x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] + atan_q(g);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= neg_s[NSTG] ? -x_s[NSTG] : x_s[NSTG];
			sin_val <= neg_s[NSTG] ? -y_s[NSTG] : y_s[NSTG];
		end
	end

endmodule
`default_nettype wire

>>> rtl/jet_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jet_divider
// Pipelined restoring divider: trunc(num * 2^24 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module jet_divider
	import jet_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic signed [NUM_W-1:0] den,
	output logic signed [QUO_W-1:0]      quo
);

	localparam logic [QUO_W-1:0] LIM = {1'b1, {(QUO_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] MAX = {1'b0, {(QUO_W-1){1'b1}}};

	logic [NUM_W-1:0] un, ud;
	logic             ovf;

	logic [NUM_W-1:0] r_s   [QUO_W+1];
	logic [NUM_W-1:0] d_s   [QUO_W+1];
	logic [QUO_W-1:0] low_s [QUO_W+1];
	logic [QUO_W-1:0] q_s   [QUO_W+1];
	logic             neg_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	logic [QUO_W-1:0] qsat;

	always_comb begin
		un  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		ud  = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
		ovf = {8'b0, un} >= {ud, 8'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= un >> 8;
			d_s[0]   <= ud;
			low_s[0] <= {un[7:0], 24'b0};
			q_s[0]   <= '0;
			neg_s[0] <= num[NUM_W-1] ^ den[NUM_W-1];
			ovf_s[0] <= ovf;
		end
	end

	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		logic [NUM_W:0] r2;
		logic [NUM_W:0] diff;
		logic           ge;
		always_comb begin
			r2   = {r_s[g], low_s[g][QUO_W-1]};
			diff = r2 - {1'b0, d_s[g]};
			ge   = r2 >= {1'b0, d_s[g]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[g+1]   <= ge ? diff[NUM_W-1:0] : r2[NUM_W-1:0];
				d_s[g+1]   <= d_s[g];
				low_s[g+1] <= low_s[g] << 1;
				q_s[g+1]   <= {q_s[g][QUO_W-2:0], ge};
				neg_s[g+1] <= neg_s[g];
				ovf_s[g+1] <= ovf_s[g];
			end
		end
	end

	assign qsat = (ovf_s[QUO_W] || (q_s[QUO_W] > LIM)) ? LIM : q_s[QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[QUO_W]) begin
				quo <= -$signed(qsat);
			end else if (qsat >= LIM) begin
				quo <= $signed(MAX);
			end else begin
				quo <= $signed(qsat);
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/jacobian_effort_transform_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jacobian_effort_transform_top
// Effort vector transform between joint and cylindric space of a 3-link arm.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless stalled and returns one result
// per request in order. A request passes one input stage, the CORDIC pipeline
// (CORDIC_STAGES + 2, CORDIC_STAGES capped at ATAN_ENTRIES), six stages of
// Jacobian and adjugate arithmetic, the 34-stage divider and the output
// register. A stall while out_valid is high freezes the whole pipeline.
module jacobian_effort_transform_top
	import jet_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);

	localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int CL   = NSTG + 2;
	localparam int DL   = QUO_W + 2;

	typedef struct packed {
		logic               op;
		logic signed [31:0] e0;
		logic signed [31:0] e1;
		logic signed [31:0] e2;
		logic signed [31:0] e3;
		logic signed [31:0] e4;
	} side_t;

	typedef struct packed {
		logic               op;
		logic               sing;
		logic signed [31:0] e0;
		logic signed [31:0] e4;
		logic signed [31:0] m1;
		logic signed [31:0] m2;
		logic signed [31:0] m3;
	} fin_t;

	logic en;
	logic [15:0] l2_q, l3_q, l4_q;

	logic v_s1;
	side_t sd_s1;
	logic signed [ANG_W-1:0] p1_s1, p2_s1, p3_s1;

	logic signed [XY_W-1:0] c1, s1, c2, s2, c3, s3;
	logic  cv_q [CL+1];
	side_t cd_q [CL+1];

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	side_t sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;

	logic signed [50:0] l2c1_s2, l3c2_s2, l4c3_s2, l2s1_s2, l3s2_s2, l4s3_s2;
	logic signed [52:0] sa, sd, sg, sb, se, sh;
	logic signed [27:0] ja_s3, jb_s3, jd_s3, je_s3, jg_s3, jh_s3;

	logic signed [55:0] paje_s4, pbjg_s4, pdjh_s4, pejg_s4, pbjd_s4, pajh_s4;
	logic signed [59:0] ae1_s4, be2_s4, de1_s4, ee2_s4, ge1_s4, he2_s4;
	logic signed [28:0] ai_s4, bi_s4, ci_s4, di_s4, ei_s4, fi_s4;

	logic signed [56:0] gf, hf, if_f;
	logic signed [58:0] det;
	logic signed [61:0] t1, t2, t3;
	logic signed [37:0] u1, u2, u3;
	logic signed [58:0] det_s5;
	logic signed [32:0] gi_s5, hi_s5, ii_s5;
	logic signed [28:0] ai_s5, bi_s5, ci_s5, di_s5, ei_s5, fi_s5;
	logic signed [31:0] m1_s5, m2_s5, m3_s5;

	logic signed [64:0] n1a_s6, n1b_s6, n1c_s6, n2a_s6, n2b_s6, n2c_s6;
	logic signed [64:0] n3a_s6, n3b_s6, n3c_s6;
	logic signed [58:0] det_s6;
	logic signed [31:0] m1_s6, m2_s6, m3_s6;
	logic sing_s6;

	logic signed [NUM_W-1:0] n1_s7, n2_s7, n3_s7, det_s7;
	logic signed [31:0] m1_s7, m2_s7, m3_s7;
	logic sing_s7;
	logic signed [66:0] n1w, n2w, n3w;

	logic signed [QUO_W-1:0] q1, q2, q3;
	logic fv_q [DL+1];
	fin_t fd_q [DL+1];

	logic vout_q;
	out_item_t out_q;

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'sd2147483647) r = 32'sh7fffffff;
		else if (v < -38'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	assign in_stall  = vout_q & out_stall;
	assign en        = ~in_stall;
	assign out_valid = vout_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_q <= '0;
			l3_q <= '0;
			l4_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINK_UPPER: l2_q <= cfg_data;
				CFG_LINK_FORE:  l3_q <= cfg_data;
				CFG_LINK_TOOL:  l4_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits of the arithmetic stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			vout_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= cv_q[CL];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			vout_q <= fv_q[DL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= '{op: in_data.operation, e0: in_data.effort_in_0,
				e1: in_data.effort_in_1, e2: in_data.effort_in_2,
				e3: in_data.effort_in_3, e4: in_data.effort_in_4};
			p1_s1 <= ANG_W'(in_data.angle_shoulder);
			p2_s1 <= ANG_W'(in_data.angle_shoulder) + ANG_W'(in_data.angle_elbow);
			p3_s1 <= ANG_W'(in_data.angle_shoulder) + ANG_W'(in_data.angle_elbow)
				+ ANG_W'(in_data.angle_wrist);
		end
	end

	jet_cordic #(.STAGES(CORDIC_STAGES)) u_cordic1 (
		.clk(clk), .en(en), .ang(p1_s1), .cos_val(c1), .sin_val(s1));
	jet_cordic #(.STAGES(CORDIC_STAGES)) u_cordic2 (
		.clk(clk), .en(en), .ang(p2_s1), .cos_val(c2), .sin_val(s2));
	jet_cordic #(.STAGES(CORDIC_STAGES)) u_cordic3 (
		.clk(clk), .en(en), .ang(p3_s1), .cos_val(c3), .sin_val(s3));

	assign cv_q[0] = v_s1;
	assign cd_q[0] = sd_s1;

	for (genvar k = 0; k < CL; k++) begin : g_cdel
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[k+1] <= 1'b0;
			end else if (en) begin
				cv_q[k+1] <= cv_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cd_q[k+1] <= cd_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2   <= cd_q[CL];
			l2c1_s2 <= $signed({1'b0, l2_q}) * c1;
			l3c2_s2 <= $signed({1'b0, l3_q}) * c2;
			l4c3_s2 <= $signed({1'b0, l4_q}) * c3;
			l2s1_s2 <= $signed({1'b0, l2_q}) * s1;
			l3s2_s2 <= $signed({1'b0, l3_q}) * s2;
			l4s3_s2 <= $signed({1'b0, l4_q}) * s3;
		end
	end

	always_comb begin
		sg = 53'(l4c3_s2);
		sd = 53'(l3c2_s2) + sg;
		sa = 53'(l2c1_s2) + sd;
		sh = -53'(l4s3_s2);
		se = sh - 53'(l3s2_s2);
		sb = se - 53'(l2s1_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3 <= sd_s2;
			ja_s3 <= sa[49:22];
			jb_s3 <= sb[49:22];
			jd_s3 <= sd[49:22];
			je_s3 <= se[49:22];
			jg_s3 <= sg[49:22];
			jh_s3 <= sh[49:22];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4   <= sd_s3;
			paje_s4 <= ja_s3 * je_s3;
			pbjg_s4 <= jb_s3 * jg_s3;
			pdjh_s4 <= jd_s3 * jh_s3;
			pejg_s4 <= je_s3 * jg_s3;
			pbjd_s4 <= jb_s3 * jd_s3;
			pajh_s4 <= ja_s3 * jh_s3;
			ae1_s4  <= ja_s3 * sd_s3.e1;
			be2_s4  <= jb_s3 * sd_s3.e2;
			de1_s4  <= jd_s3 * sd_s3.e1;
			ee2_s4  <= je_s3 * sd_s3.e2;
			ge1_s4  <= jg_s3 * sd_s3.e1;
			he2_s4  <= jh_s3 * sd_s3.e2;
			ai_s4   <= 29'(je_s3) - 29'(jh_s3);
			bi_s4   <= 29'(jh_s3) - 29'(jb_s3);
			ci_s4   <= 29'(jb_s3) - 29'(je_s3);
			di_s4   <= 29'(jg_s3) - 29'(jd_s3);
			ei_s4   <= 29'(ja_s3) - 29'(jg_s3);
			fi_s4   <= 29'(jd_s3) - 29'(ja_s3);
		end
	end

	always_comb begin
		gf   = 57'(pdjh_s4) - 57'(pejg_s4);
		hf   = 57'(pbjg_s4) - 57'(pajh_s4);
		if_f = 57'(paje_s4) - 57'(pbjd_s4);
		det  = 59'(gf) + 59'(hf) + 59'(if_f);
		t1   = 62'(ae1_s4) + 62'(be2_s4) + (62'(sd_s4.e3) <<< 24);
		t2   = 62'(de1_s4) + 62'(ee2_s4) + (62'(sd_s4.e3) <<< 24);
		t3   = 62'(ge1_s4) + 62'(he2_s4) + (62'(sd_s4.e3) <<< 24);
		u1   = t1[61:24];
		u2   = t2[61:24];
		u3   = t3[61:24];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5  <= sd_s4;
			det_s5 <= det;
			gi_s5  <= gf[56:24];
			hi_s5  <= hf[56:24];
			ii_s5  <= if_f[56:24];
			ai_s5  <= ai_s4;
			bi_s5  <= bi_s4;
			ci_s5  <= ci_s4;
			di_s5  <= di_s4;
			ei_s5  <= ei_s4;
			fi_s5  <= fi_s4;
			m1_s5  <= sat32(u1);
			m2_s5  <= sat32(u2);
			m3_s5  <= sat32(u3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6   <= sd_s5;
			n1a_s6  <= ai_s5 * sd_s5.e1;
			n1b_s6  <= bi_s5 * sd_s5.e2;
			n1c_s6  <= ci_s5 * sd_s5.e3;
			n2a_s6  <= di_s5 * sd_s5.e1;
			n2b_s6  <= ei_s5 * sd_s5.e2;
			n2c_s6  <= fi_s5 * sd_s5.e3;
			n3a_s6  <= gi_s5 * sd_s5.e1;
			n3b_s6  <= hi_s5 * sd_s5.e2;
			n3c_s6  <= ii_s5 * sd_s5.e3;
			det_s6  <= det_s5;
			m1_s6   <= m1_s5;
			m2_s6   <= m2_s5;
			m3_s6   <= m3_s5;
			sing_s6 <= ~sd_s5.op && (det_s5 == '0);
		end
	end

	always_comb begin
		n1w = 67'(n1a_s6) + 67'(n1b_s6) + 67'(n1c_s6);
		n2w = 67'(n2a_s6) + 67'(n2b_s6) + 67'(n2c_s6);
		n3w = 67'(n3a_s6) + 67'(n3b_s6) + 67'(n3c_s6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7   <= sd_s6;
			n1_s7   <= n1w[NUM_W-1:0];
			n2_s7   <= n2w[NUM_W-1:0];
			n3_s7   <= n3w[NUM_W-1:0];
			det_s7  <= NUM_W'(det_s6);
			m1_s7   <= m1_s6;
			m2_s7   <= m2_s6;
			m3_s7   <= m3_s6;
			sing_s7 <= sing_s6;
		end
	end

	jet_divider u_div1 (.clk(clk), .en(en), .num(n1_s7), .den(det_s7), .quo(q1));
	jet_divider u_div2 (.clk(clk), .en(en), .num(n2_s7), .den(det_s7), .quo(q2));
	jet_divider u_div3 (.clk(clk), .en(en), .num(n3_s7), .den(det_s7), .quo(q3));

	assign fv_q[0] = v_s7;
	assign fd_q[0] = '{op: sd_s7.op, sing: sing_s7, e0: sd_s7.e0, e4: sd_s7.e4,
		m1: m1_s7, m2: m2_s7, m3: m3_s7};

	for (genvar k = 0; k < DL; k++) begin : g_fdel
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fv_q[k+1] <= 1'b0;
			end else if (en) begin
				fv_q[k+1] <= fv_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				fd_q[k+1] <= fd_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fd_q[DL].op) begin
				out_q <= '{effort_out_0: fd_q[DL].e0, effort_out_1: fd_q[DL].m1,
					effort_out_2: fd_q[DL].m2, effort_out_3: fd_q[DL].m3,
					effort_out_4: fd_q[DL].e4, singular: 1'b0};
			end else if (fd_q[DL].sing) begin
				out_q <= '{effort_out_0: '0, effort_out_1: '0, effort_out_2: '0,
					effort_out_3: '0, effort_out_4: '0, singular: 1'b1};
			end else begin
				out_q <= '{effort_out_0: fd_q[DL].e0, effort_out_1: q1,
					effort_out_2: q2, effort_out_3: q3,
					effort_out_4: fd_q[DL].e4, singular: 1'b0};
			end
		end
	end

endmodule
`default_nettype wire
